// ----- sv/range_max_segment_tree_core_assert.svh -----
// assertion macros for the range maximum segment tree core
// both macros sample on clk_i and are disabled while rst_ni is low
`ifndef RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RMST_ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define RMST_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RMST_ASSERT_SAME(name, pre, post, msg)
`define RMST_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ----- sv/rmst_pkg.sv -----
package rmst_pkg;

  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned LEAF_W    = $clog2(LEAVES);
  localparam int unsigned NODE_AW   = LEAF_W + 1;
  localparam int unsigned PTR_W     = NODE_AW + 1;
  localparam int unsigned LEN_W     = LEAF_W + 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned S_TDATA_W = ((2 * LEAF_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam logic signed [DATA_W-1:0] SMALLEST = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic upd_leaf;
    logic upd_up;
    logic qry_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic upd_ok;
    logic upd_last;
    logic qry_done;
  } dp_sts_t;

  function automatic logic signed [DATA_W-1:0] max_s(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/rmst_ctrl.sv -----
module rmst_ctrl import rmst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_cmd_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t dp_cmd_o,
  input  dp_sts_t dp_sts_i
);

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ULEAF = 6'b000100,
    S_UUP   = 6'b001000,
    S_QRY   = 6'b010000,
    S_RES   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    case (state_q)
      S_CLR: begin
        dp_cmd_o.clr_step = 1'b1;
        if (dp_sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          dp_cmd_o.load = 1'b1;
          if (cmd_e'(in_cmd_i) == CMD_QUERY) begin
            state_d = S_QRY;
          end else if (dp_sts_i.upd_ok) begin
            state_d = S_ULEAF;
          end
        end
      end
      S_ULEAF: begin
        dp_cmd_o.upd_leaf = 1'b1;
        state_d = S_UUP;
      end
      S_UUP: begin
        dp_cmd_o.upd_up = 1'b1;
        if (dp_sts_i.upd_last) begin
          state_d = S_IDLE;
        end
      end
      S_QRY: begin
        // last read data is folded in during the done cycle
        if (dp_sts_i.qry_done) begin
          state_d = S_RES;
        end else begin
          dp_cmd_o.qry_step = 1'b1;
        end
      end
      S_RES: begin
        if (out_free) begin
          dp_cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (dp_cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ----- sv/rmst_dp.sv -----
module rmst_dp import rmst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  dp_cmd_i,
  output dp_sts_t                  dp_sts_o,
  input  logic [LEAF_W-1:0]        first_index_i,
  input  logic [LEAF_W-1:0]        last_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     cfg_we_i,
  input  logic [LEN_W-1:0]         cfg_wdata_i,
  output logic signed [DATA_W-1:0] range_max_o
);

  // node memory, node 0 unused, leaves at LEAVES and up
  logic signed [DATA_W-1:0] mem [2*LEAVES];

  logic [LEN_W-1:0]   len_q;
  logic [NODE_AW-1:0] clr_q;
  logic [NODE_AW-1:0] pos_q;
  logic [PTR_W-1:0]   lo_q, hi_q;
  logic               va_q, vb_q;
  logic signed [DATA_W-1:0] cur_q, best_q, rd_a_q, rd_b_q, out_q;

  logic [LEN_W-1:0]   len_use;
  logic               in_range, q_ok;
  logic [LEAF_W-1:0]  last_c;
  logic [PTR_W-1:0]   lo_init, hi_init, lo_next, hi_next;
  logic [NODE_AW-1:0] par;
  logic signed [DATA_W-1:0] up_max, sel_a, sel_b, acc;
  logic               we;
  logic [NODE_AW-1:0] waddr, addr_a, addr_b;
  logic signed [DATA_W-1:0] wdata;

  // range set-up on the incoming item
  always_comb begin
    len_use  = (len_q > LEN_W'(LEAVES)) ? LEN_W'(LEAVES) : len_q;
    in_range = {1'b0, first_index_i} < len_use;
    last_c   = ({1'b0, last_index_i} >= len_use) ? LEAF_W'(len_use - LEN_W'(1))
                                                 : last_index_i;
    q_ok     = in_range && (first_index_i <= last_c);
    lo_init  = q_ok ? PTR_W'(LEAVES) + PTR_W'(first_index_i) : '0;
    hi_init  = q_ok ? PTR_W'(LEAVES) + PTR_W'(last_c) + PTR_W'(1) : '0;
  end

  // one level of the bottom-up range walk
  assign lo_next = (lo_q + PTR_W'(lo_q[0])) >> 1;
  assign hi_next = hi_q >> 1;

  assign par    = {1'b0, pos_q[NODE_AW-1:1]};
  assign up_max = max_s(cur_q, rd_a_q);

  assign sel_a = va_q ? rd_a_q : SMALLEST;
  assign sel_b = vb_q ? rd_b_q : SMALLEST;
  assign acc   = max_s(best_q, max_s(sel_a, sel_b));

  always_comb begin
    we     = 1'b0;
    waddr  = pos_q;
    wdata  = cur_q;
    addr_a = lo_q[NODE_AW-1:0];
    if (dp_cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = SMALLEST;
    end else if (dp_cmd_i.upd_leaf) begin
      we     = 1'b1;
      addr_a = {pos_q[NODE_AW-1:1], ~pos_q[0]};
    end else if (dp_cmd_i.upd_up) begin
      we     = 1'b1;
      waddr  = par;
      wdata  = up_max;
      addr_a = {par[NODE_AW-1:1], ~par[0]};
    end
  end

  assign addr_b = {hi_q[NODE_AW-1:1], 1'b0};

  assign dp_sts_o.clr_last = (clr_q == '1);
  assign dp_sts_o.upd_ok   = in_range;
  assign dp_sts_o.upd_last = (par == NODE_AW'(1));
  assign dp_sts_o.qry_done = (lo_q >= hi_q);

  assign range_max_o = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(LEAVES);
      clr_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (dp_cmd_i.clr_step) begin
        clr_q <= clr_q + NODE_AW'(1);
      end
      va_q <= dp_cmd_i.qry_step & lo_q[0];
      vb_q <= dp_cmd_i.qry_step & hi_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      pos_q  <= NODE_AW'(LEAVES) + NODE_AW'(first_index_i);
      cur_q  <= value_i;
      lo_q   <= lo_init;
      hi_q   <= hi_init;
      best_q <= SMALLEST;
    end else begin
      if (dp_cmd_i.upd_up) begin
        pos_q <= par;
        cur_q <= up_max;
      end
      if (dp_cmd_i.qry_step) begin
        lo_q <= lo_next;
        hi_q <= hi_next;
      end
      best_q <= acc;
    end
    if (dp_cmd_i.out_load) begin
      out_q <= best_q;
    end
  end

endmodule

// ----- sv/range_max_segment_tree_core.sv -----
// range maximum segment tree: keeps signed 32-bit entries in a 2048-word node
// memory (one write port, two registered read ports) where each inner node holds
// the maximum of its two children. after reset the block sweeps the memory to
// the smallest signed value, one node a cycle; s_axis_tready stays low during
// that pass while configuration writes are still taken. an update item
// (tuser 0) writes the leaf and then rewrites one ancestor per cycle with
// one sibling read each, and no new item is taken until the root is written;
// an update beyond the length in use is dropped. a query item (tuser 1) walks
// the tree bottom-up one level per cycle, reading up to two nodes per level
// through the two read ports; an empty or out-of-range query returns the
// smallest signed value. the result sits in an output register, so the next
// item is accepted while it waits. cfg_wdata_i sets the number of entries in
// use, saturated to 1024; the user must write it only while the block is idle,
// the block itself does not enforce this, and a write never clears entries.
`include "range_max_segment_tree_core_assert.svh"

module range_max_segment_tree_core import rmst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // first_index, last_index, value, zero pad
  input  logic                 s_axis_tuser,   // cmd
  // result item stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // range_max
  // active length register
  input  logic                 cfg_we_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  logic [LEAF_W-1:0]        first_index;
  logic [LEAF_W-1:0]        last_index;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] range_max;

  // unpack the item fields, lowest first
  assign first_index = s_axis_tdata[LEAF_W-1:0];
  assign last_index  = s_axis_tdata[2*LEAF_W-1:LEAF_W];
  assign value       = s_axis_tdata[2*LEAF_W+DATA_W-1:2*LEAF_W];

  assign m_axis_tdata = M_TDATA_W'(range_max);

  // sequencer: clear pass, update path walk, query walk, result hand-off
  rmst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  // node memory, walk pointers and max accumulators
  rmst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_sts_o      (dp_sts),
    .first_index_i (first_index),
    .last_index_i  (last_index),
    .value_i       (value),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .range_max_o   (range_max)
  );

  // at most one node-memory writer or walk step per cycle
  `RMST_ASSERT_SAME(a_one_op, 1'b1, $onehot0({dp_cmd.clr_step, dp_cmd.upd_leaf, dp_cmd.upd_up, dp_cmd.qry_step}), "more than one datapath operation in a cycle")
  // no item taken while the clear pass runs
  `RMST_ASSERT_SAME(a_no_accept_clr, dp_cmd.clr_step, !s_axis_tready, "item accepted during clear pass")
  // a result never overwrites one that was not taken
  `RMST_ASSERT_SAME(a_no_overwrite, dp_cmd.out_load, !m_axis_tvalid || m_axis_tready, "pending result overwritten")
  // a loaded result is offered in the next cycle
  `RMST_ASSERT_NEXT(a_out_shown, dp_cmd.out_load, m_axis_tvalid, "loaded result not offered")

endmodule
